// ===== rtl/dbat_pkg.sv =====
// Shared types, constants and helper functions of the decimal block affine transform.
package dbat_pkg;

  localparam int VAL_W  = 34;
  localparam int DIG_W  = 40;
  localparam int IDX_W  = 64;
  localparam int PROD_W = 67;
  localparam int RED_SH = 34;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [DIG_W-1:0]  dig_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DIGIT = 2'd2
  } status_t;

  localparam val_t MOD10 = 34'd10000000000;
  localparam val_t MULK  = 34'd3816547291;
  localparam val_t ADDK  = 34'd7261940353;

  localparam idx_t KEYX   = 64'hA5A5F0F01234ABCD;
  localparam idx_t GOLDEN = 64'h9E3779B97F4A7C15;
  localparam idx_t MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam idx_t MIX_C2 = 64'h94D049BB133111EB;

  localparam logic [35:0] MOD10_X2 = 36'd20000000000;
  localparam logic [68:0] TWO_68   = 69'd1 << 68;
  localparam logic [34:0] RED_RCP  = 35'(TWO_68 / 69'(MOD10));

  localparam logic [31:0] PHI_M1 = 32'd3999999999;

  localparam logic [29:0] DIV1E5_RCP = 30'd703687442;
  localparam int          DIV1E5_SH  = 41;
  localparam logic [16:0] HALF_DEC   = 17'd100000;
  localparam logic [14:0] DIV125_RCP = 15'd16778;
  localparam logic [8:0]  DIV25_RCP  = 9'd328;
  localparam logic [7:0]  DIV10_RCP  = 8'd205;

  localparam int MIX_LAT  = 5;
  localparam int RED_LAT  = 4;
  localparam int MUL_LAT  = 2 + RED_LAT;
  localparam int BCD_LAT  = 4;
  localparam int OFF_IDX  = MIX_LAT + RED_LAT - 1;
  localparam int PRE_IDX  = OFF_IDX + 1;
  localparam int MUL_IDX  = PRE_IDX + MUL_LAT;
  localparam int POST_IDX = MUL_IDX + 1;
  localparam int PIPE_N   = POST_IDX + BCD_LAT + 1;

  typedef struct packed {
    logic        mode;
    logic        over;
    logic        bad;
    val_t        pv;
    val_t        acc;
    val_t        off;
    logic [16:0] lo5;
    logic [16:0] hi5;
    status_t     status;
    logic        big;
  } sb_t;

  function automatic val_t mulmod_c(input val_t a, input val_t b);
    logic [35:0] r;
    r = '0;
    for (int i = VAL_W - 1; i >= 0; i--) begin
      r = (r << 1) % 36'(MOD10);
      if (b[i]) begin
        r = (r + 36'(a)) % 36'(MOD10);
      end
    end
    return val_t'(r);
  endfunction

  function automatic val_t inverse_c(input val_t m);
    val_t res;
    val_t base;
    res  = 34'd1;
    base = m;
    for (int i = 0; i < 32; i++) begin
      if (PHI_M1[i]) begin
        res = mulmod_c(res, base);
      end
      base = mulmod_c(base, base);
    end
    return res;
  endfunction

  localparam val_t MINV = inverse_c(MULK);

  function automatic val_t addmod(input val_t a, input val_t b);
    logic [34:0] s;
    s = 35'(a) + 35'(b);
    return (s >= 35'(MOD10)) ? val_t'(s - 35'(MOD10)) : val_t'(s);
  endfunction

  function automatic val_t submod(input val_t a, input val_t b);
    logic [34:0] s;
    s = 35'(a) + 35'(MOD10) - 35'(b);
    return (a >= b) ? (a - b) : val_t'(s);
  endfunction

endpackage

// ===== rtl/dbat_modred.sv =====
// Four-stage reduction of a wide product modulo ten to the tenth.
module dbat_modred (
  input  logic            clk,
  input  logic            en,
  input  dbat_pkg::prod_t din,
  output dbat_pkg::val_t  dout
);
  import dbat_pkg::*;

  logic [67:0] pr_r, pr_nxt;
  logic [35:0] lo1_r, lo1_nxt;
  logic [35:0] lo2_r, lo2_nxt;
  logic [35:0] qm_r, qm_nxt;
  logic [34:0] r1_r, r1_nxt;
  val_t        out_r, out_nxt;
  logic [33:0] q;
  logic [35:0] r;

  always_comb begin
    pr_nxt  = 68'(din[PROD_W-1:RED_SH]) * 68'(RED_RCP);
    lo1_nxt = din[35:0];
    q       = pr_r[67:RED_SH];
    qm_nxt  = 36'(36'(q) * 36'(MOD10));
    lo2_nxt = lo1_r;
    r       = lo2_r - qm_r;
    r1_nxt  = (r >= MOD10_X2) ? 35'(r - MOD10_X2) : 35'(r);
    out_nxt = (r1_r >= 35'(MOD10)) ? val_t'(r1_r - 35'(MOD10)) : val_t'(r1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r  <= pr_nxt;
      lo1_r <= lo1_nxt;
      qm_r  <= qm_nxt;
      lo2_r <= lo2_nxt;
      r1_r  <= r1_nxt;
      out_r <= out_nxt;
    end
  end

  assign dout = out_r;

endmodule

// ===== rtl/dbat_mix.sv =====
// Five-stage splitmix64 finalizer of the keyed block index.
module dbat_mix (
  input  logic           clk,
  input  logic           en,
  input  dbat_pkg::idx_t idx,
  output dbat_pkg::idx_t hash
);
  import dbat_pkg::*;

  idx_t        a_r, a_nxt;
  logic [63:0] ll1_r, ll1_nxt;
  logic [31:0] x1_r, x1_nxt;
  idx_t        u_r, u_nxt;
  logic [63:0] ll2_r, ll2_nxt;
  logic [31:0] x2_r, x2_nxt;
  idx_t        h_r, h_nxt;
  idx_t        t;
  idx_t        y;
  idx_t        z;

  always_comb begin
    t       = (idx ^ KEYX) + GOLDEN;
    a_nxt   = t ^ (t >> 30);
    ll1_nxt = 64'(a_r[31:0]) * 64'(MIX_C1[31:0]);
    x1_nxt  = 32'(a_r[63:32] * MIX_C1[31:0]) + 32'(a_r[31:0] * MIX_C1[63:32]);
    y       = ll1_r + {x1_r, 32'd0};
    u_nxt   = y ^ (y >> 27);
    ll2_nxt = 64'(u_r[31:0]) * 64'(MIX_C2[31:0]);
    x2_nxt  = 32'(u_r[63:32] * MIX_C2[31:0]) + 32'(u_r[31:0] * MIX_C2[63:32]);
    z       = ll2_r + {x2_r, 32'd0};
    h_nxt   = z ^ (z >> 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      ll1_r <= ll1_nxt;
      x1_r  <= x1_nxt;
      u_r   <= u_nxt;
      ll2_r <= ll2_nxt;
      x2_r  <= x2_nxt;
      h_r   <= h_nxt;
    end
  end

  assign hash = h_r;

endmodule

// ===== rtl/dbat_mulmod.sv =====
// Modular product of two values below ten to the tenth, six stages deep.
module dbat_mulmod (
  input  logic           clk,
  input  logic           en,
  input  dbat_pkg::val_t a,
  input  dbat_pkg::val_t k,
  output dbat_pkg::val_t y
);
  import dbat_pkg::*;

  logic [63:0] ll_r, ll_nxt;
  logic [33:0] lh_r, lh_nxt;
  logic [33:0] hl_r, hl_nxt;
  logic [3:0]  hh_r, hh_nxt;
  prod_t       p_r, p_nxt;

  always_comb begin
    ll_nxt = 64'(a[31:0]) * 64'(k[31:0]);
    lh_nxt = 34'(a[31:0]) * 34'(k[33:32]);
    hl_nxt = 34'(a[33:32]) * 34'(k[31:0]);
    hh_nxt = 4'(a[33:32]) * 4'(k[33:32]);
    p_nxt  = prod_t'(ll_r) + (prod_t'(lh_r) << 32) + (prod_t'(hl_r) << 32)
           + (prod_t'(hh_r) << 64);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
      p_r  <= p_nxt;
    end
  end

  dbat_modred u_red (
    .clk  (clk),
    .en   (en),
    .din  (p_r),
    .dout (y)
  );

endmodule

// ===== rtl/dbat_bcd.sv =====
// Four-stage conversion of a binary value below ten to the tenth into ten BCD digits.
module dbat_bcd (
  input  logic           clk,
  input  logic           en,
  input  dbat_pkg::val_t val,
  output dbat_pkg::dig_t digits
);
  import dbat_pkg::*;

  logic [58:0] pr_r, pr_nxt;
  val_t        v1_r, v1_nxt;
  logic [16:0] half_r [2];
  logic [16:0] half_nxt [2];
  logic [6:0]  a_r [2];
  logic [6:0]  a_nxt [2];
  logic [9:0]  b_r [2];
  logic [9:0]  b_nxt [2];
  logic [19:0] dg_r [2];
  logic [19:0] dg_nxt [2];
  logic [16:0] hi;
  logic [3:0]  c [2];
  logic [6:0]  b2 [2];

  function automatic logic [7:0] two_digits(input logic [6:0] n);
    logic [3:0] tens;
    tens = 4'((15'(n) * 15'(DIV10_RCP)) >> 11);
    return {tens, 4'(n - 7'(tens) * 7'd10)};
  endfunction

  always_comb begin
    pr_nxt      = 59'(val[33:5]) * 59'(DIV1E5_RCP);
    v1_nxt      = val;
    hi          = 17'(pr_r >> DIV1E5_SH);
    half_nxt[1] = hi;
    half_nxt[0] = 17'(v1_r - 34'(hi) * 34'(HALF_DEC));
    for (int h = 0; h < 2; h++) begin
      a_nxt[h]  = 7'((29'(half_r[h] >> 3) * 29'(DIV125_RCP)) >> 21);
      b_nxt[h]  = 10'(half_r[h] - 17'(a_nxt[h]) * 17'd1000);
      c[h]      = 4'((17'(b_r[h] >> 2) * 17'(DIV25_RCP)) >> 13);
      b2[h]     = 7'(b_r[h] - 10'(c[h]) * 10'd100);
      dg_nxt[h] = {two_digits(a_r[h]), c[h], two_digits(b2[h])};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_r   <= pr_nxt;
      v1_r   <= v1_nxt;
      half_r <= half_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      dg_r   <= dg_nxt;
    end
  end

  assign digits = {dg_r[1], dg_r[0]};

endmodule

// ===== rtl/decimal_block_affine_transform_unit.sv =====
// Top level of the decimal block affine transform: keyed offset, affine step and BCD output.
// One beat is accepted every cycle unless a shown result is stalled; then the whole pipeline holds.
// Both modes share the single modular multiplier; it and the offset hash are both pipelined.
// Synchronous active-low reset clears only the stage valid bits; no clearing pass is needed.
module decimal_block_affine_transform_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_mode,
  input  dbat_pkg::val_t in_plain_value,
  input  dbat_pkg::dig_t in_code_digits,
  input  dbat_pkg::idx_t in_block_index,
  output logic           out_valid,
  input  logic           out_stall,
  output dbat_pkg::val_t out_result_value,
  output dbat_pkg::dig_t out_result_digits,
  output logic [1:0]     out_status,
  output logic           out_above_32_bits
);
  import dbat_pkg::*;

  logic              en;
  logic [PIPE_N-1:0] vld_r, vld_nxt;
  sb_t               sb_r [PIPE_N];
  sb_t               sb_nxt [PIPE_N];
  idx_t              hash_w;
  val_t              off_w;
  val_t              y_w;
  dig_t              dig_w;
  logic [3:0]        nib;
  logic [16:0]       lo5;
  logic [16:0]       hi5;
  logic              bad;
  sb_t               pre;
  sb_t               post;

  always_comb begin
    en      = !vld_r[PIPE_N-1] || !out_stall;
    vld_nxt = {vld_r[PIPE_N-2:0], in_valid};

    bad = 1'b0;
    lo5 = '0;
    hi5 = '0;
    for (int j = 4; j >= 0; j--) begin
      nib = in_code_digits[4*j +: 4];
      bad = bad || (nib > 4'd9);
      lo5 = 17'(lo5 * 17'd10 + 17'(nib));
      nib = in_code_digits[4*(j+5) +: 4];
      bad = bad || (nib > 4'd9);
      hi5 = 17'(hi5 * 17'd10 + 17'(nib));
    end

    sb_nxt[0]      = '0;
    sb_nxt[0].mode = in_mode;
    sb_nxt[0].over = in_plain_value >= MOD10;
    sb_nxt[0].bad  = bad;
    sb_nxt[0].pv   = in_plain_value;
    sb_nxt[0].lo5  = lo5;
    sb_nxt[0].hi5  = hi5;
    for (int i = 1; i < PIPE_N; i++) begin
      sb_nxt[i] = sb_r[i-1];
    end

    sb_nxt[1].acc = 34'(sb_r[0].hi5) * 34'(HALF_DEC) + 34'(sb_r[0].lo5);
    sb_nxt[2].acc = submod(sb_r[1].acc, ADDK);

    pre     = sb_r[OFF_IDX];
    pre.off = off_w;
    if (!pre.mode) begin
      pre.acc = addmod(pre.pv, off_w);
    end
    sb_nxt[PRE_IDX] = pre;

    post        = sb_r[MUL_IDX];
    post.status = ST_OK;
    post.big    = 1'b0;
    if (!post.mode) begin
      if (post.over) begin
        post.status = ST_RANGE;
        post.acc    = '0;
      end else begin
        post.acc = addmod(y_w, ADDK);
      end
    end else begin
      if (post.bad) begin
        post.status = ST_DIGIT;
        post.acc    = '0;
      end else begin
        post.acc = submod(y_w, post.off);
        post.big = |post.acc[33:32];
      end
    end
    sb_nxt[POST_IDX] = post;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r <= sb_nxt;
    end
  end

  dbat_mix u_mix (
    .clk  (clk),
    .en   (en),
    .idx  (in_block_index),
    .hash (hash_w)
  );

  dbat_modred u_off (
    .clk  (clk),
    .en   (en),
    .din  (prod_t'(hash_w)),
    .dout (off_w)
  );

  dbat_mulmod u_mul (
    .clk (clk),
    .en  (en),
    .a   (sb_r[PRE_IDX].acc),
    .k   (sb_r[PRE_IDX].mode ? MINV : MULK),
    .y   (y_w)
  );

  dbat_bcd u_bcd (
    .clk    (clk),
    .en     (en),
    .val    (sb_r[POST_IDX].acc),
    .digits (dig_w)
  );

  assign in_stall          = !en;
  assign out_valid         = vld_r[PIPE_N-1];
  assign out_result_value  = sb_r[PIPE_N-1].acc;
  assign out_result_digits = dig_w;
  assign out_status        = sb_r[PIPE_N-1].status;
  assign out_above_32_bits = sb_r[PIPE_N-1].big;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_result_value == '0) && (out_result_digits == '0) && !out_above_32_bits)
    else $error("Error beat carries a nonzero result.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_value < MOD10))
    else $error("Result value is not reduced.");

  a_big: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_above_32_bits |-> (out_result_value[33:32] != 2'b00))
    else $error("Wide flag set on a value that fits in 32 bits.");

  a_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_digits[39:36] <= 4'd9) && (out_result_digits[3:0] <= 4'd9))
    else $error("Result digit out of decimal range.");

endmodule

// ===== dv/tb_decimal_block_affine_transform_unit.sv =====
// Testbench for the decimal block affine transform: a queue-fed driver, a monitor and a predictor.
`timescale 1ns / 100ps

module tb_decimal_block_affine_transform_unit;
  import dbat_pkg::*;

  localparam logic [63:0] TEN10 = 64'd10000000000;
  localparam logic [63:0] MUL_C = 64'd3816547291;
  localparam logic [63:0] ADD_C = 64'd7261940353;
  localparam int LATENCY = 20;

  typedef struct {
    logic        mode;
    logic [33:0] plain;
    logic [39:0] digits;
    logic [63:0] index;
  } beat_t;

  typedef struct {
    logic [33:0] value;
    logic [39:0] digits;
    logic [1:0]  status;
    logic        big;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  val_t        in_plain_value = '0;
  dig_t        in_code_digits = '0;
  idx_t        in_block_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  val_t        out_result_value;
  dig_t        out_result_digits;
  logic [1:0]  out_status;
  logic        out_above_32_bits;

  beat_t    pending_beats[$];
  outcome_t expected_outcomes[$];
  int       error_count = 0;
  int       send_wait = 0;
  int       recv_wait = 0;
  logic     in_taken = 1'b0;
  logic     out_taken = 1'b0;

  decimal_block_affine_transform_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_plain_value(in_plain_value), .in_code_digits(in_code_digits),
    .in_block_index(in_block_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_result_digits(out_result_digits),
    .out_status(out_status), .out_above_32_bits(out_above_32_bits)
  );

  function automatic logic [63:0] key_offset(input logic [63:0] index);
    logic [63:0] x;
    x = (index ^ 64'hA5A5F0F01234ABCD) + 64'h9E3779B97F4A7C15;
    x = (x ^ (x >> 30)) * 64'hBF58476D1CE4E5B9;
    x = (x ^ (x >> 27)) * 64'h94D049BB133111EB;
    x = x ^ (x >> 31);
    return x % TEN10;
  endfunction

  function automatic logic [63:0] times_mod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p % 128'(TEN10));
  endfunction

  function automatic logic [63:0] inverse_of(input logic [63:0] m);
    longint t;
    longint nt;
    longint r;
    longint nr;
    longint q;
    longint tmp;
    t = 0;
    nt = 1;
    r = longint'(TEN10);
    nr = longint'(m);
    while (nr != 0) begin
      q = r / nr;
      tmp = t - q * nt;
      t = nt;
      nt = tmp;
      tmp = r - q * nr;
      r = nr;
      nr = tmp;
    end
    if (t < 0) t += longint'(TEN10);
    return 64'(t);
  endfunction

  function automatic logic [39:0] as_bcd(input logic [63:0] v);
    logic [39:0] d;
    d = '0;
    for (int i = 0; i < 10; i++) begin
      d[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return d;
  endfunction

  function automatic outcome_t transform_beat(input beat_t b);
    outcome_t    r;
    logic [63:0] e;
    logic [63:0] v;
    logic        bad;
    r = '{value: '0, digits: '0, status: ST_OK, big: 1'b0};
    if (!b.mode) begin
      if (64'(b.plain) >= TEN10) begin
        r.status = ST_RANGE;
        return r;
      end
      v = (times_mod(MUL_C, (64'(b.plain) + key_offset(b.index)) % TEN10) + ADD_C) % TEN10;
    end else begin
      e = 0;
      bad = 1'b0;
      for (int i = 9; i >= 0; i--) begin
        if (b.digits[4*i +: 4] > 4'd9) bad = 1'b1;
        else e = e * 10 + 64'(b.digits[4*i +: 4]);
        if (b.digits[4*i +: 4] > 4'd9) e = e * 10;
      end
      if (bad) begin
        r.status = ST_DIGIT;
        return r;
      end
      v = times_mod((e + TEN10 - ADD_C) % TEN10, inverse_of(MUL_C));
      v = (v + TEN10 - key_offset(b.index)) % TEN10;
      r.big = (v > 64'hFFFFFFFF);
    end
    r.value = 34'(v);
    r.digits = as_bcd(v);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic logic [39:0] random_digits(input bit allow_bad);
    logic [39:0] d;
    for (int i = 0; i < 10; i++) begin
      d[4*i +: 4] = allow_bad ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 9));
    end
    return d;
  endfunction

  function automatic logic [63:0] random_index();
    return {$urandom, $urandom};
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (pending_beats.size() > 0) begin
        in_valid <= 1'b1;
        in_mode <= pending_beats[0].mode;
        in_plain_value <= pending_beats[0].plain;
        in_code_digits <= pending_beats[0].digits;
        in_block_index <= pending_beats[0].index;
        expected_outcomes.insert(expected_outcomes.size(), transform_beat(pending_beats[0]));
        void'(pending_beats.pop_front());
        send_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_result_value), 0);
      end else begin
        want = expected_outcomes.pop_front();
        if (out_result_value !== want.value)
          report_mismatch("result_value", 64'(out_result_value), 64'(want.value));
        if (out_result_digits !== want.digits)
          report_mismatch("result_digits", 64'(out_result_digits), 64'(want.digits));
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_above_32_bits !== want.big)
          report_mismatch("above_32_bits", 64'(out_above_32_bits), 64'(want.big));
      end
    end
  end

  task automatic add_encode(input logic [33:0] v, input logic [63:0] index);
    pending_beats.insert(pending_beats.size(),
                         '{mode: 1'b0, plain: v, digits: 40'($urandom), index: index});
  endtask

  task automatic add_decode(input logic [39:0] d, input logic [63:0] index);
    pending_beats.insert(pending_beats.size(),
                         '{mode: 1'b1, plain: 34'($urandom), digits: d, index: index});
  endtask

  initial begin
    beat_t b;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_encode(34'd0, 64'd0);
    add_encode(34'd9999999999, 64'hFFFFFFFFFFFFFFFF);
    add_encode(34'd10000000000, 64'd1);
    add_encode(34'h3FFFFFFFF, 64'hA5A5F0F01234ABCD);
    add_encode(34'd4294967295, 64'd2);
    add_encode(34'd4294967296, 64'h8000000000000000);
    add_decode(40'h0000000000, 64'd0);
    add_decode(40'h9999999999, 64'hFFFFFFFFFFFFFFFF);
    add_decode(40'hFFFFFFFFFF, 64'd3);
    add_decode(40'hA000000000, 64'd4);
    add_decode(40'h000000000A, 64'd5);
    add_decode(40'h7261940353, 64'hA5A5F0F01234ABCD);
    add_decode(as_bcd(transform_beat('{1'b0, 34'd4294967296, '0, 64'd9}).value), 64'd9);
    add_decode(as_bcd(transform_beat('{1'b0, 34'd4294967295, '0, 64'd9}).value), 64'd9);
    for (int i = 0; i < 1750; i++) begin
      b.index = random_index();
      case ($urandom_range(0, 9))
        0: add_encode(34'({$urandom, $urandom}), b.index);
        1: add_decode(random_digits(1'b1), b.index);
        2, 3, 4: add_encode(34'({$urandom, $urandom} % TEN10), b.index);
        5, 6: add_decode(random_digits(1'b0), b.index);
        default: add_decode(as_bcd(transform_beat(
                   '{1'b0, 34'({$urandom, $urandom} % TEN10), '0, b.index}).value), b.index);
      endcase
    end

    wait (pending_beats.size() == 0 && !(in_valid && in_stall));
    @(posedge clk);
    wait (expected_outcomes.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
